[sv/length_prefixed_packet_deframer_defines.svh]
// assertion helpers for the deframer
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_DEFINES_SVH

// same-cycle implication, skipped while reset is high
`define LPPD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lppd check failed");

// next-cycle implication, skipped while reset is high
`define LPPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lppd check failed");

`endif

[sv/lppd_pkg.sv]
package lppd_pkg;

   localparam logic [7:0] CODE_C1 = 8'hC1;
   localparam logic [7:0] CODE_C2 = 8'hC2;
   localparam logic [7:0] CODE_C3 = 8'hC3;
   localparam logic [7:0] CODE_C4 = 8'hC4;

   localparam logic [15:0] HDR_SHORT = 16'd2;
   localparam logic [15:0] HDR_LONG  = 16'd3;
   localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BADCODE = 2'd1,
      ST_BADLEN  = 2'd2,
      ST_TOOLONG = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      PH_HUNT = 5'b00001,
      PH_LEN1 = 5'b00010,
      PH_LENH = 5'b00100,
      PH_LENL = 5'b01000,
      PH_BODY = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       in_packet;
      logic       first_byte;
      logic       last_byte;
      status_type status;
   } rsp_type;

endpackage

[sv/lppd_in_reg.sv]
module lppd_in_reg import lppd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_data
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
      if (load) begin
         data_in = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[sv/lppd_parser.sv]
module lppd_parser import lppd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  logic [7:0]  rx_byte,
   input  logic        step,
   output rsp_type     result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [15:0] max_len_ff, max_len_in;

   logic [15:0] total;
   logic [15:0] header;

   assign max_len_in = csr_we ? csr_wdata : max_len_ff;

   always_comb begin
      total  = {8'd0, rx_byte};
      header = HDR_SHORT;
      if (phase_ff == PH_LENL) begin
         total  = {length_high_ff, rx_byte};
         header = HDR_LONG;
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      length_high_in    = length_high_ff;
      bytes_left_in     = bytes_left_ff;
      result.out_byte   = rx_byte;
      result.in_packet  = 1'b0;
      result.first_byte = 1'b0;
      result.last_byte  = 1'b0;
      result.status     = ST_OK;
      case (phase_ff)
         PH_LEN1, PH_LENL: begin
            // length below the header covers length zero as well
            if (total < header) begin
               result.status = ST_BADLEN;
               phase_in      = PH_HUNT;
            end else if (total > max_len_ff) begin
               result.status = ST_TOOLONG;
               phase_in      = PH_HUNT;
            end else if (total == header) begin
               result.in_packet = 1'b1;
               result.last_byte = 1'b1;
               bytes_left_in    = 16'd0;
               phase_in         = PH_HUNT;
            end else begin
               result.in_packet = 1'b1;
               bytes_left_in    = total - header;
               phase_in         = PH_BODY;
            end
         end
         PH_LENH: begin
            result.in_packet = 1'b1;
            length_high_in   = rx_byte;
            phase_in         = PH_LENL;
         end
         PH_BODY: begin
            result.in_packet = 1'b1;
            if (bytes_left_ff <= 16'd1) begin
               result.last_byte = 1'b1;
               bytes_left_in    = 16'd0;
               phase_in         = PH_HUNT;
            end else begin
               bytes_left_in = bytes_left_ff - 16'd1;
            end
         end
         default: begin
            phase_in = PH_HUNT;
            if (rx_byte inside {CODE_C1, CODE_C3}) begin
               phase_in          = PH_LEN1;
               result.in_packet  = 1'b1;
               result.first_byte = 1'b1;
            end else if (rx_byte inside {CODE_C2, CODE_C4}) begin
               phase_in          = PH_LENH;
               result.in_packet  = 1'b1;
               result.first_byte = 1'b1;
            end else begin
               result.status = ST_BADCODE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         length_high_ff <= 8'd0;
         bytes_left_ff  <= 16'd0;
         max_len_ff     <= MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
         if (step) begin
            phase_ff       <= phase_in;
            length_high_ff <= length_high_in;
            bytes_left_ff  <= bytes_left_in;
         end
      end
   end

endmodule

[sv/lppd_out_reg.sv]
module lppd_out_reg import lppd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
         data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[sv/length_prefixed_packet_deframer.sv]
// channel   direction  ports            contents
// req       in         req_t*           one received byte a request
// rsp       out        rsp_t*           the byte with packet marks and status
// csr       in         csr_we/wdata     maximum total packet length
//
// one byte per cycle sustained while rsp_tready is held high; a request goes
// through the input register, the header/length decode and the result register.
// the phase, length and byte count registers update as a byte moves into the
// result register, so bytes follow each other with no bubble.
// reset clears the valid flags and the framing state, maximum back to 65535.
// a stall on rsp backs up through both registers to req_tready.
`include "length_prefixed_packet_deframer_defines.svh"

module length_prefixed_packet_deframer import lppd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // last_byte
   output logic [3:0]  rsp_tuser,   // [0] in_packet, [1] first_byte, [3:2] status
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic       mid_valid, mid_ready;
   logic [7:0] mid_byte;
   logic       step;
   rsp_type    parsed, rsp;

   lppd_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_byte)
   );

   assign step = mid_valid && mid_ready;

   lppd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rx_byte   (mid_byte),
      .step      (step),
      .result    (parsed)
   );

   lppd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (parsed),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = rsp.out_byte;
   assign rsp_tlast = rsp.last_byte;
   assign rsp_tuser = {rsp.status, rsp.first_byte, rsp.in_packet};

   `LPPD_ASSERT_IMPL(a_first_ok, clock, reset, rsp_tvalid && rsp.first_byte, rsp.in_packet && rsp.status == ST_OK)
   `LPPD_ASSERT_IMPL(a_last_in_pkt, clock, reset, rsp_tvalid && rsp.last_byte, rsp.in_packet && !rsp.first_byte)
   `LPPD_ASSERT_IMPL(a_err_dropped, clock, reset, rsp_tvalid && rsp.status != ST_OK, !rsp.in_packet)
   `LPPD_ASSERT_IMPL(a_empty_ready, clock, reset, !rsp_tvalid, req_tready)

endmodule
